>>> sv/header_field_end_scanner_macros.svh
// Assertion macros used by the header field end scanner top level.
`ifndef HEADER_FIELD_END_SCANNER_MACROS_SVH
`define HEADER_FIELD_END_SCANNER_MACROS_SVH
`ifndef ASSERT_OFF
`define HFES_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define HFES_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define HFES_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define HFES_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

>>> sv/hfes_pkg.sv
// Shared types, constants and codes of the header field end scanner.
`timescale 1ns / 1ps
package hfes_pkg;

  localparam int MAX_BUFFER_LEN = 65536;
  localparam int POS_W = $clog2(MAX_BUFFER_LEN + 1);
  localparam int OFS_W = 18;
  localparam int CMP_W = ((POS_W > OFS_W) ? POS_W : OFS_W) + 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int S_DATA_W = 32;
  localparam int M_DATA_W = 40;

  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_EQ  = 8'h3D;
  localparam logic [7:0] CH_0   = 8'h30;
  localparam logic [7:0] CH_2   = 8'h32;
  localparam logic [7:0] CH_9   = 8'h39;

  typedef enum logic [1:0] {
    ST_END_FOUND = 2'd0,
    ST_BEYOND    = 2'd1,
    ST_ABSENT    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    PH_IDLE        = 3'd0,
    PH_WAIT_START  = 3'd1,
    PH_START_LF    = 3'd2,
    PH_START_LF_WS = 3'd3,
    PH_SEARCH      = 3'd4,
    PH_AFTER_LF    = 3'd5,
    PH_AFTER_EQ    = 3'd6,
    PH_AFTER_EQ2   = 3'd7
  } phase_t;

  // One classified byte as it travels from the front to the back.
  typedef struct packed {
    logic                    first;
    logic                    last;
    logic signed [OFS_W-1:0] start_offset;
    logic                    is_lf;
    logic                    is_blank;
    logic                    is_eq;
    logic                    is_0;
    logic                    is_2;
    logic                    is_9;
  } item_t;

  typedef struct packed {
    status_t          status;
    logic [OFS_W-1:0] field_end;
    logic [OFS_W-1:0] body_begin;
    logic             folded;
  } result_t;

  typedef struct packed {
    logic pop;
    logic emit;
  } back_ctl_t;

endpackage

>>> sv/header_field_end_scanner.sv
// Top level of the header field end scanner: front end, queue and back end.
`timescale 1ns / 1ps
// Usage: the slave channel carries one byte of a message buffer per request,
// in order from offset zero. tuser marks the first byte of a buffer, which
// starts a new scan and carries the field body start offset in tdata; tlast
// marks the final byte. A first byte in the middle of a scan restarts it.
// The master channel carries at most one result request per buffer, sent as
// soon as the end of the header field is decided: tuser holds the status,
// tdata the field end, the body start and the folded flag.
// Throughput is one byte per clock while the result register is not stalled,
// set by the back end state machine, which takes one queued byte each cycle.
// An accepted byte passes through the two-entry queue and then the result
// register before its result reaches the master side.
// Reset clears the scan state, empties the queue and drops m_tvalid; no
// memory needs clearing, so bytes are taken from the first cycle after reset.
// When the receiver stalls, the result register holds its request, the back
// end stops taking bytes, and once the queue is full s_tready goes low.
`include "header_field_end_scanner_macros.svh"
module header_field_end_scanner (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // s_tdata, low bit up: data_byte[7:0], start_offset[25:8], zero fill.
  input  logic [hfes_pkg::S_DATA_W-1:0] s_tdata,
  // s_tuser: first_byte.
  input  logic                          s_tuser,
  input  logic                          s_tlast,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // m_tdata, low bit up: field_end[17:0], body_begin[35:18], was_folded[36],
  // zero fill.
  output logic [hfes_pkg::M_DATA_W-1:0] m_tdata,
  // m_tuser: scan_status[1:0].
  output logic [1:0]                    m_tuser
);

  localparam int OW = hfes_pkg::OFS_W;

  logic                push;
  logic                q_full;
  logic                q_valid;
  hfes_pkg::item_t     push_item;
  hfes_pkg::item_t     q_item;
  hfes_pkg::back_ctl_t ctl;
  hfes_pkg::result_t   result;

  // The front end classifies each byte so the back end only tests flags.
  hfes_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .push     (push),
    .item     (push_item)
  );

  // The queue lets the front keep accepting while the back end is held.
  hfes_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (ctl.pop),
    .q_valid   (q_valid),
    .q_full    (q_full),
    .q_item    (q_item)
  );

  hfes_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .ctl      (ctl),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .result   (result)
  );

  assign m_tuser = result.status;
  assign m_tdata = {{(hfes_pkg::M_DATA_W - 2 * OW - 1){1'b0}},
                    result.folded, result.body_begin, result.field_end};

  `HFES_ASSERT_IMPLY(a_no_pop_while_stalled, clk, rst, m_tvalid && !m_tready, !ctl.pop, "back end took a byte while the result was stalled")
  `HFES_ASSERT_NEXT(a_emit_reaches_output, clk, rst, ctl.pop && ctl.emit, m_tvalid, "decided result did not reach the output register")
  `HFES_ASSERT_IMPLY(a_absent_result_form, clk, rst, m_tvalid && (m_tuser == hfes_pkg::ST_ABSENT), (m_tdata[OW-1:0] == '1) && !m_tdata[2*OW], "absent header result has wrong end or folded flag")
  `HFES_ASSERT_IMPLY(a_beyond_not_folded, clk, rst, m_tvalid && (m_tuser == hfes_pkg::ST_BEYOND), !m_tdata[2*OW], "start beyond buffer reported as folded")

endmodule

>>> sv/hfes_front.sv
// Front end: accepts request bytes and classifies them for the back end.
`timescale 1ns / 1ps
module hfes_front (
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [hfes_pkg::S_DATA_W-1:0] s_tdata,
  input  logic                          s_tuser,
  input  logic                          s_tlast,
  input  logic                          q_full,
  output logic                          push,
  output hfes_pkg::item_t               item
);

  logic [7:0] c;

  assign c        = s_tdata[7:0];
  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;

  always_comb begin
    item.first        = s_tuser;
    item.last         = s_tlast;
    item.start_offset = s_tdata[8 +: hfes_pkg::OFS_W];
    item.is_lf        = (c == hfes_pkg::CH_LF);
    item.is_blank     = (c == hfes_pkg::CH_SP) || (c == hfes_pkg::CH_TAB);
    item.is_eq        = (c == hfes_pkg::CH_EQ);
    item.is_0         = (c == hfes_pkg::CH_0);
    item.is_2         = (c == hfes_pkg::CH_2);
    item.is_9         = (c == hfes_pkg::CH_9);
  end

endmodule

>>> sv/hfes_queue.sv
// Short queue of classified bytes between the front and back ends.
`timescale 1ns / 1ps
module hfes_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  hfes_pkg::item_t push_item,
  input  logic            pop,
  output logic            q_valid,
  output logic            q_full,
  output hfes_pkg::item_t q_item
);

  hfes_pkg::item_t                   entries [hfes_pkg::QUEUE_DEPTH];
  logic [hfes_pkg::QPTR_W-1:0]       wptr;
  logic [hfes_pkg::QPTR_W-1:0]       rptr;
  logic [hfes_pkg::QCNT_W-1:0]       count;

  function automatic logic [hfes_pkg::QPTR_W-1:0] bump(input logic [hfes_pkg::QPTR_W-1:0] p);
    if (p == hfes_pkg::QPTR_W'(hfes_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + hfes_pkg::QPTR_W'(1);
  endfunction

  assign q_valid = (count != '0);
  assign q_full  = (count == hfes_pkg::QCNT_W'(hfes_pkg::QUEUE_DEPTH));
  assign q_item  = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= bump(wptr);
      end
      if (pop) begin
        rptr <= bump(rptr);
      end
      if (push && !pop) begin
        count <= count + hfes_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - hfes_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

>>> sv/hfes_back.sv
// Back end: scan state machine and the registered result stage.
`timescale 1ns / 1ps
module hfes_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  hfes_pkg::item_t     q_item,
  output hfes_pkg::back_ctl_t ctl,
  output logic                m_tvalid,
  input  logic                m_tready,
  output hfes_pkg::result_t   result
);

  localparam int PW = hfes_pkg::POS_W;
  localparam int OW = hfes_pkg::OFS_W;
  localparam int CW = hfes_pkg::CMP_W;

  hfes_pkg::phase_t phase, phase_next;
  logic [PW-1:0]    pos, pos_next;
  logic [OW-1:0]    start, start_next;
  logic [PW-1:0]    cand, cand_next;
  logic             folded, folded_next;
  logic             la_zero, la_zero_next;
  logic             pop;
  logic             emit;
  hfes_pkg::result_t res;

  hfes_pkg::phase_t ph;
  logic [PW-1:0]    pos_c;
  logic             run;

  function automatic logic [PW-1:0] sat_len(input logic [PW-1:0] p);
    if (p >= PW'(hfes_pkg::MAX_BUFFER_LEN)) begin
      return PW'(hfes_pkg::MAX_BUFFER_LEN);
    end
    return p + PW'(1);
  endfunction

  function automatic logic [OW-1:0] to_ofs(input logic [PW-1:0] p);
    logic [CW-1:0] w;
    w = CW'(p);
    return w[OW-1:0];
  endfunction

  assign pop      = q_valid && (!m_tvalid || m_tready);
  assign ctl.pop  = pop;
  assign ctl.emit = emit;

  always_comb begin
    ph           = phase;
    pos_c        = pos;
    start_next   = start;
    cand_next    = cand;
    folded_next  = folded;
    la_zero_next = la_zero;
    emit         = 1'b0;
    run          = 1'b1;
    res.status     = hfes_pkg::ST_END_FOUND;
    res.field_end  = '0;
    res.body_begin = '0;
    res.folded     = 1'b0;

    if (q_item.first) begin
      pos_c        = '0;
      start_next   = q_item.start_offset;
      folded_next  = 1'b0;
      cand_next    = '0;
      la_zero_next = 1'b0;
      if (q_item.start_offset[OW-1]) begin
        emit           = 1'b1;
        res.status     = hfes_pkg::ST_ABSENT;
        res.field_end  = '1;
        res.body_begin = start_next;
        ph             = hfes_pkg::PH_IDLE;
        run            = 1'b0;
      end else begin
        ph = hfes_pkg::PH_WAIT_START;
      end
    end else if (phase == hfes_pkg::PH_IDLE) begin
      run = 1'b0;
    end

    phase_next = ph;
    if (run) begin
      case (ph)
        hfes_pkg::PH_WAIT_START: begin
          if (CW'(pos_c) == CW'(start_next)) begin
            cand_next = pos_c;
            if (q_item.is_lf) begin
              if (q_item.last) begin
                emit          = 1'b1;
                res.field_end = to_ofs(pos_c);
              end else begin
                phase_next = hfes_pkg::PH_START_LF;
              end
            end else if (q_item.last) begin
              emit          = 1'b1;
              res.field_end = to_ofs(sat_len(pos_c));
            end else begin
              phase_next = hfes_pkg::PH_SEARCH;
            end
          end else if (q_item.last) begin
            emit          = 1'b1;
            res.status    = hfes_pkg::ST_BEYOND;
            res.field_end = to_ofs(sat_len(pos_c));
          end
        end
        hfes_pkg::PH_START_LF: begin
          if (q_item.is_blank && !q_item.last) begin
            phase_next = hfes_pkg::PH_START_LF_WS;
          end else begin
            emit          = 1'b1;
            res.field_end = to_ofs(cand_next);
          end
        end
        hfes_pkg::PH_START_LF_WS: begin
          start_next = start_next + OW'(2);
          cand_next  = pos_c;
          if (q_item.is_lf) begin
            emit          = 1'b1;
            res.field_end = to_ofs(pos_c);
          end else if (q_item.last) begin
            emit          = 1'b1;
            res.field_end = to_ofs(sat_len(pos_c));
          end else begin
            phase_next = hfes_pkg::PH_SEARCH;
          end
        end
        hfes_pkg::PH_SEARCH: begin
          if (q_item.is_lf) begin
            cand_next = pos_c;
            if (q_item.last) begin
              emit          = 1'b1;
              res.field_end = to_ofs(pos_c);
              res.folded    = folded_next;
            end else begin
              phase_next = hfes_pkg::PH_AFTER_LF;
            end
          end else if (q_item.last) begin
            emit          = 1'b1;
            res.field_end = to_ofs(sat_len(pos_c));
            res.folded    = folded_next;
          end
        end
        hfes_pkg::PH_AFTER_LF: begin
          if (q_item.is_blank) begin
            folded_next = 1'b1;
            if (q_item.last) begin
              emit          = 1'b1;
              res.field_end = to_ofs(sat_len(pos_c));
              res.folded    = 1'b1;
            end else begin
              phase_next = hfes_pkg::PH_SEARCH;
            end
          end else if (q_item.is_eq && !q_item.last) begin
            phase_next = hfes_pkg::PH_AFTER_EQ;
          end else begin
            emit          = 1'b1;
            res.field_end = to_ofs(cand_next);
            res.folded    = folded_next;
          end
        end
        hfes_pkg::PH_AFTER_EQ: begin
          la_zero_next = q_item.is_0;
          if ((q_item.is_0 || q_item.is_2) && !q_item.last) begin
            phase_next = hfes_pkg::PH_AFTER_EQ2;
          end else begin
            emit          = 1'b1;
            res.field_end = to_ofs(cand_next);
            res.folded    = folded_next;
          end
        end
        hfes_pkg::PH_AFTER_EQ2: begin
          // "=09" and "=20" are treated as a tab or space continuation.
          if ((la_zero && q_item.is_9) || (!la_zero && q_item.is_0)) begin
            folded_next = 1'b1;
            if (q_item.last) begin
              emit          = 1'b1;
              res.field_end = to_ofs(sat_len(pos_c));
              res.folded    = 1'b1;
            end else begin
              phase_next = hfes_pkg::PH_SEARCH;
            end
          end else begin
            emit          = 1'b1;
            res.field_end = to_ofs(cand_next);
            res.folded    = folded_next;
          end
        end
        default: begin
          phase_next = hfes_pkg::PH_IDLE;
        end
      endcase
      if (emit) begin
        res.body_begin = start_next;
        phase_next     = hfes_pkg::PH_IDLE;
      end
    end

    if (run && (pos_c < PW'(hfes_pkg::MAX_BUFFER_LEN))) begin
      pos_next = pos_c + PW'(1);
    end else begin
      pos_next = pos_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= hfes_pkg::PH_IDLE;
      pos     <= '0;
      start   <= '0;
      cand    <= '0;
      folded  <= 1'b0;
      la_zero <= 1'b0;
    end else if (pop) begin
      phase   <= phase_next;
      pos     <= pos_next;
      start   <= start_next;
      cand    <= cand_next;
      folded  <= folded_next;
      la_zero <= la_zero_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop && emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      result <= res;
    end
  end

endmodule

>>> sim/tb_header_field_end_scanner.sv
// Self-checking testbench for the header field end scanner, with a byte-level predictor.
`timescale 1ns / 1ps
module tb_header_field_end_scanner;
  import hfes_pkg::*;

  // The random part stops once this many bytes have been offered and taken.
  localparam int BYTE_TARGET = 1950;
  // Set well above what a correct run needs, even if every byte waited out
  // the longest sender gap and receiver stall.
  localparam int CYCLE_LIMIT = 1_500_000;
  // Length of the one long receiver hold-off that backs the block up.
  localparam int LONG_HOLD = 400;

  typedef struct packed {
    status_t     status;
    logic [17:0] field_end;
    logic [17:0] body_begin;
    logic        folded;
  } scan_result_t;

  typedef struct {
    logic [7:0]         data;
    bit                 first;
    logic signed [17:0] offset;
    bit                 last;
    bit                 has_want;
    scan_result_t       want;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic                s_tuser = 1'b0;
  logic                s_tlast = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic [1:0]          m_tuser;

  header_field_end_scanner dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Results the block still owes, oldest first.
  scan_result_t awaited_ends[$];
  dir_row_t     dir_tab[$];
  int           mismatch_count = 0;
  int           cycle_count = 0;
  bit           sender_quiet = 1'b0;
  bit           hold_now = 1'b0;

  // Predictor state: the scan as the block should see it.
  logic [16:0] scan_pos = '0;
  int          body_start = 0;
  phase_t      scan_ph = PH_IDLE;
  logic [7:0]  eq_digit = '0;
  logic [16:0] cand_end = '0;
  bit          fold_seen = 1'b0;

  // Buffer length up to and including position p, saturated at the bound.
  function automatic logic [17:0] len_to(logic [16:0] p);
    return (p >= MAX_BUFFER_LEN) ? 18'(MAX_BUFFER_LEN) : 18'(p) + 18'd1;
  endfunction

  function automatic void post_result(status_t st, logic [17:0] fend, bit fl);
    scan_result_t r;
    r.status     = st;
    r.field_end  = fend;
    r.body_begin = body_start[17:0];
    r.folded     = fl;
    awaited_ends.push_back(r);
    scan_ph = PH_IDLE;
  endfunction

  // Advances the predicted scan by one accepted byte. used is 0 when the byte
  // falls outside any scan and the block simply drops it.
  task automatic predict_field_end(input logic [7:0] c, input bit first,
                                   input logic signed [17:0] ofs, input bit last,
                                   output bit used);
    logic [16:0] p;
    bit          blank;
    used  = 1'b1;
    blank = (c == CH_SP) || (c == CH_TAB);
    if (first) begin
      scan_pos   = '0;
      body_start = int'(ofs);
      fold_seen  = 1'b0;
      eq_digit   = '0;
      cand_end   = '0;
      if (body_start < 0) begin
        // Header absent: answered on the first byte, the rest is dropped.
        post_result(ST_ABSENT, '1, 1'b0);
        return;
      end
      scan_ph = PH_WAIT_START;
    end else if (scan_ph == PH_IDLE) begin
      used = 1'b0;
      return;
    end
    p = scan_pos;
    case (scan_ph)
      PH_WAIT_START: begin
        if (int'(p) == body_start) begin
          cand_end = p;
          if (c == CH_LF) begin
            if (last) post_result(ST_END_FOUND, 18'(p), 1'b0);
            else scan_ph = PH_START_LF;
          end else if (last) begin
            post_result(ST_END_FOUND, len_to(p), 1'b0);
          end else begin
            scan_ph = PH_SEARCH;
          end
        end else if (last) begin
          post_result(ST_BEYOND, len_to(p), 1'b0);
        end
      end
      PH_START_LF: begin
        if (blank && !last) scan_ph = PH_START_LF_WS;
        else post_result(ST_END_FOUND, 18'(cand_end), 1'b0);
      end
      PH_START_LF_WS: begin
        // The empty first line is skipped, so the body moves past it.
        body_start += 2;
        cand_end = p;
        if (c == CH_LF) post_result(ST_END_FOUND, 18'(p), 1'b0);
        else if (last) post_result(ST_END_FOUND, len_to(p), 1'b0);
        else scan_ph = PH_SEARCH;
      end
      PH_SEARCH: begin
        if (c == CH_LF) begin
          cand_end = p;
          if (last) post_result(ST_END_FOUND, 18'(p), fold_seen);
          else scan_ph = PH_AFTER_LF;
        end else if (last) begin
          post_result(ST_END_FOUND, len_to(p), fold_seen);
        end
      end
      PH_AFTER_LF: begin
        if (blank) begin
          fold_seen = 1'b1;
          if (last) post_result(ST_END_FOUND, len_to(p), 1'b1);
          else scan_ph = PH_SEARCH;
        end else if (c == CH_EQ && !last) begin
          scan_ph = PH_AFTER_EQ;
        end else begin
          post_result(ST_END_FOUND, 18'(cand_end), fold_seen);
        end
      end
      PH_AFTER_EQ: begin
        eq_digit = c;
        if ((c == CH_0 || c == CH_2) && !last) scan_ph = PH_AFTER_EQ2;
        else post_result(ST_END_FOUND, 18'(cand_end), fold_seen);
      end
      PH_AFTER_EQ2: begin
        // Only the encoded tab and space count as a continuation.
        if ((eq_digit == CH_0 && c == CH_9) || (eq_digit == CH_2 && c == CH_0)) begin
          fold_seen = 1'b1;
          if (last) post_result(ST_END_FOUND, len_to(p), 1'b1);
          else scan_ph = PH_SEARCH;
        end else begin
          post_result(ST_END_FOUND, 18'(cand_end), fold_seen);
        end
      end
      default: scan_ph = PH_IDLE;
    endcase
    if (scan_pos < MAX_BUFFER_LEN) scan_pos++;
  endtask

  task automatic report_mismatch(input string what, input logic [17:0] got,
                                 input logic [17:0] want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $time);
  endtask

  // Sender gaps: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (sender_quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic logic [7:0] text_byte();
    return 8'($urandom_range(8'h21, 8'h7E));
  endfunction

  function automatic logic [7:0] blank_byte();
    return $urandom_range(0, 1) ? CH_SP : CH_TAB;
  endfunction

  function automatic void add_step(logic [7:0] d, bit first, logic signed [17:0] ofs,
                                   bit last, bit has_want, status_t st,
                                   logic [17:0] fend, logic [17:0] body, bit fl);
    dir_row_t row;
    row.data            = d;
    row.first           = first;
    row.offset          = ofs;
    row.last            = last;
    row.has_want        = has_want;
    row.want.status     = st;
    row.want.field_end  = fend;
    row.want.body_begin = body;
    row.want.folded     = fl;
    dir_tab.push_back(row);
  endfunction

  // Offers one byte request, waits for the handshake and feeds the predictor.
  task automatic send_byte(input logic [7:0] c, input bit first,
                           input logic signed [17:0] ofs, input bit last,
                           output bit used);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(S_DATA_W - 26){1'b0}}, ofs, c};
    s_tuser  <= first;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_field_end(c, first, ofs, last, used);
  endtask

  // Builds one buffer from well-formed pieces (plain text, folds, encoded
  // folds and broken ones), picks a start that mostly lands on the body, and
  // sends it. A few buffers lose their final byte so that the next first byte
  // restarts the scan, and a few are followed by stray bytes.
  task automatic send_random_buffer(inout int counted);
    logic [7:0]         text[$];
    int                 len_goal;
    int                 prefix;
    int                 pick;
    int                 v;
    logic signed [17:0] ofs;
    bit                 cut;
    bit                 used;
    len_goal = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 14);
    prefix   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
    repeat (prefix) text.push_back(text_byte());
    if ($urandom_range(0, 3) == 0) begin
      text.push_back(CH_LF);
      text.push_back(blank_byte());
    end
    while (text.size() < len_goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        text.push_back(text_byte());
      end else if (pick < 75) begin
        text.push_back(CH_LF);
        if (pick < 45) begin
          text.push_back(blank_byte());
        end else if (pick < 55) begin
          text.push_back(CH_EQ); text.push_back(CH_0); text.push_back(CH_9);
        end else if (pick < 65) begin
          text.push_back(CH_EQ); text.push_back(CH_2); text.push_back(CH_0);
        end else begin
          text.push_back(CH_EQ);
          case ($urandom_range(0, 3))
            0: begin text.push_back(CH_0); text.push_back(text_byte()); end
            1: begin text.push_back(CH_2); text.push_back(8'h31); end
            2: text.push_back(CH_0);
            default: ;
          endcase
        end
      end else if (pick < 85) begin
        text.push_back(CH_LF);
      end else if (pick < 92) begin
        text.push_back(8'($urandom_range(0, 255)));
      end else begin
        case ($urandom_range(0, 4))
          0: text.push_back(blank_byte());
          1: text.push_back(CH_EQ);
          2: text.push_back(CH_0);
          3: text.push_back(CH_2);
          default: text.push_back(CH_9);
        endcase
      end
    end
    pick = $urandom_range(0, 99);
    if (pick < 72) v = prefix;
    else if (pick < 80) v = $urandom_range(0, text.size() - 1);
    else if (pick < 88) v = $urandom_range(0, 4) == 0 ? 131071 : text.size() + $urandom_range(0, 3);
    else v = -$urandom_range(1, 131072);
    ofs = 18'(v);
    cut = ($urandom_range(0, 11) == 0);
    foreach (text[i]) begin
      send_byte(text[i], i == 0, (i == 0) ? ofs : 18'($urandom),
                (i == text.size() - 1) && !cut, used);
      counted++;
    end
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        send_byte(8'($urandom_range(0, 255)), 1'b0, 18'($urandom),
                  $urandom_range(0, 1), used);
        counted++;
      end
    end
  endtask

  // Receiver: ready runs of random length, mostly short stalls, and now and
  // then a long ready stretch. When asked, it holds off for a long time so
  // that the queue inside the block fills and s_tready drops.
  initial begin : result_sink
    int r;
    int stall;
    forever begin
      if (hold_now) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_now = 1'b0;
      end
      m_tready <= 1'b1;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12))
        @(posedge clk);
      r = $urandom_range(0, 99);
      stall = (r < 50) ? 0 : (r < 85) ? $urandom_range(1, 2) :
              (r < 96) ? $urandom_range(3, 8) : $urandom_range(20, 60);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Every accepted result is compared, field by field, with the oldest one owed.
  always @(posedge clk) begin : result_check
    scan_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (awaited_ends.size() == 0) begin
        report_mismatch("result with nothing owed", m_tdata[17:0], '0);
      end else begin
        want = awaited_ends.pop_front();
        if (m_tuser != want.status)
          report_mismatch("scan_status", 18'(m_tuser), 18'(want.status));
        if (m_tdata[17:0] != want.field_end)
          report_mismatch("field_end", m_tdata[17:0], want.field_end);
        if (m_tdata[35:18] != want.body_begin)
          report_mismatch("body_begin", m_tdata[35:18], want.body_begin);
        if (m_tdata[36] != want.folded)
          report_mismatch("was_folded", 18'(m_tdata[36]), 18'(want.folded));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    int counted;
    bit used;
    bit burst_done;
    counted    = 0;
    burst_done = 1'b0;

    // Header absent, with the smallest negative start as well.
    add_step("A", 1, -18'sd1, 0, 1, ST_ABSENT, 18'h3FFFF, 18'h3FFFF, 0);
    // A byte with no scan running is dropped.
    add_step(8'hFF, 0, 18'h3FFFF, 1, 0, ST_END_FOUND, 0, 0, 0);
    add_step(8'h00, 1, 18'h20000, 1, 1, ST_ABSENT, 18'h3FFFF, 18'h20000, 0);
    // Start beyond a one-byte buffer, at the largest offset.
    add_step("q", 1, 18'h1FFFF, 1, 1, ST_BEYOND, 18'd1, 18'h1FFFF, 0);
    // A line feed that is the final byte ends the field.
    add_step(CH_LF, 1, 0, 1, 1, ST_END_FOUND, 0, 0, 0);
    // Empty first line followed by a space: the body start moves by two.
    add_step(CH_LF, 1, 0, 0, 0, ST_END_FOUND, 0, 0, 0);
    add_step(CH_SP, 0, 0, 0, 0, ST_END_FOUND, 0, 0, 0);
    add_step("x", 0, 0, 0, 0, ST_END_FOUND, 0, 0, 0);
    add_step(CH_LF, 0, 0, 1, 0, ST_END_FOUND, 0, 0, 0);
    // Empty first line followed by text ends right there.
    add_step(CH_LF, 1, 0, 0, 0, ST_END_FOUND, 0, 0, 0);
    add_step("y", 0, 0, 1, 1, ST_END_FOUND, 0, 0, 0);
    // Tab fold, encoded tab, encoded space, then a broken encoding ends it.
    add_step("h", 1, 0, 0, 0, ST_END_FOUND, 0, 0, 0);
    add_step(CH_LF, 0, 0, 0, 0, ST_END_FOUND, 0, 0, 0);
    add_step(CH_TAB, 0, 0, 0, 0, ST_END_FOUND, 0, 0, 0);
    add_step(CH_LF, 0, 0, 0, 0, ST_END_FOUND, 0, 0, 0);
    add_step(CH_EQ, 0, 0, 0, 0, ST_END_FOUND, 0, 0, 0);
    add_step(CH_0, 0, 0, 0, 0, ST_END_FOUND, 0, 0, 0);
    add_step(CH_9, 0, 0, 0, 0, ST_END_FOUND, 0, 0, 0);
    add_step(CH_LF, 0, 0, 0, 0, ST_END_FOUND, 0, 0, 0);
    add_step(CH_EQ, 0, 0, 0, 0, ST_END_FOUND, 0, 0, 0);
    add_step(CH_2, 0, 0, 0, 0, ST_END_FOUND, 0, 0, 0);
    add_step(CH_0, 0, 0, 0, 0, ST_END_FOUND, 0, 0, 0);
    add_step(CH_LF, 0, 0, 0, 0, ST_END_FOUND, 0, 0, 0);
    add_step(CH_EQ, 0, 0, 0, 0, ST_END_FOUND, 0, 0, 0);
    add_step(CH_2, 0, 0, 0, 0, ST_END_FOUND, 0, 0, 0);
    add_step(8'h31, 0, 0, 0, 0, ST_END_FOUND, 0, 0, 0);
    // The rest of a decided buffer is dropped.
    add_step(CH_SP, 0, 0, 1, 0, ST_END_FOUND, 0, 0, 0);
    // A first byte in the middle of a scan restarts it.
    add_step("a", 1, 5, 0, 0, ST_END_FOUND, 0, 0, 0);
    add_step("c", 1, 0, 1, 0, ST_END_FOUND, 0, 0, 0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[k]) begin
      send_byte(dir_tab[k].data, dir_tab[k].first, dir_tab[k].offset, dir_tab[k].last,
                used);
      // Rows with a hand-written answer replace the predicted one.
      if (dir_tab[k].has_want) begin
        void'(awaited_ends.pop_back());
        awaited_ends.push_back(dir_tab[k].want);
      end
    end

    while (counted < BYTE_TARGET) begin
      if (!burst_done && counted >= 700) begin
        // Absent-header buffers answer at once, so a stalled receiver soon
        // backs the block up while the sender keeps offering.
        burst_done   = 1'b1;
        hold_now     = 1'b1;
        sender_quiet = 1'b1;
        repeat (24) begin
          send_byte(text_byte(), 1'b1, 18'(-$urandom_range(1, 131072)), 1'b1, used);
          counted++;
        end
      end
      sender_quiet = ($urandom_range(0, 6) == 0);
      send_random_buffer(counted);
    end
    sender_quiet = 1'b0;

    s_tvalid <= 1'b0;
    while (awaited_ends.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
